// ===== src/cas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_pkg
// Shared types, constants and helpers of the command-line argument splitter.
// ----------------------------------------------------------------------------
package cas_pkg;

  localparam int unsigned RUN_W  = 5;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned NUM_W  = 8;

  localparam logic [RUN_W-1:0] SLASH_MAX = 5'd31;
  localparam logic [NUM_W-1:0] ARG_MAX   = 8'd255;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;

  // Command queue between the classifier and the result generator.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef enum logic [1:0] {
    K_CHAR   = 2'd0,
    K_ARGEND = 2'd1,
    K_STREND = 2'd2
  } kind_e;

  // One classified input item: a run of held backslashes, then up to two
  // further results.
  typedef struct packed {
    logic [RUN_W-1:0]  nbs;
    logic [NUM_W-1:0]  idx;
    logic              t0_v;
    kind_e             t0_kind;
    logic [CHAR_W-1:0] t0_char;
    logic              t1_v;
    logic [NUM_W-1:0]  t1_num;
  } cmd_t;

  function automatic logic [NUM_W-1:0] cur_index(input logic [NUM_W-1:0] cnt);
    cur_index = (cnt == '0) ? '0 : cnt - 1'b1;
  endfunction

endpackage

// ===== src/cas_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_front
// Classifies each input byte against the quoting state and queues a command.
// ----------------------------------------------------------------------------
module cas_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          ch_i,
  output logic                cmd_push_o,
  output cas_pkg::cmd_t       cmd_o
);
  import cas_pkg::*;

  logic             in_arg_q, in_arg_d;
  logic             quoting_q, quoting_d;
  logic             pending_q, pending_d;
  logic [RUN_W-1:0] run_q, run_d;
  logic [NUM_W-1:0] cnt_q, cnt_d;
  logic             quoting_eff;
  logic [NUM_W-1:0] cnt_begin;
  cmd_t             cmd;

  assign cnt_begin = in_arg_q ? cnt_q : ((cnt_q < ARG_MAX) ? cnt_q + 1'b1 : cnt_q);

  always_comb begin
    // A pending quote always ends quoting, whatever the byte is.
    quoting_eff = pending_q ? 1'b0 : quoting_q;
    in_arg_d    = in_arg_q;
    quoting_d   = quoting_eff;
    pending_d   = 1'b0;
    run_d       = run_q;
    cnt_d       = cnt_q;
    cmd         = '0;
    cmd.t0_kind = K_CHAR;
    if (pending_q && ch_i == CH_QUOTE) begin
      cmd.t0_v    = 1'b1;
      cmd.t0_char = CH_QUOTE;
      cmd.idx     = cur_index(cnt_q);
    end else if (ch_i == CH_NUL) begin
      cmd.nbs     = run_q;
      cmd.idx     = cur_index(cnt_q);
      cmd.t0_v    = in_arg_q;
      cmd.t0_kind = K_ARGEND;
      cmd.t1_v    = 1'b1;
      cmd.t1_num  = cnt_q;
      in_arg_d    = 1'b0;
      quoting_d   = 1'b0;
      run_d       = '0;
      cnt_d       = '0;
    end else if (ch_i == CH_BSLASH) begin
      in_arg_d = 1'b1;
      cnt_d    = cnt_begin;
      if (run_q < SLASH_MAX) begin
        run_d = run_q + 1'b1;
      end
    end else if (ch_i == CH_QUOTE) begin
      in_arg_d = 1'b1;
      cnt_d    = cnt_begin;
      cmd.nbs  = run_q >> 1;
      cmd.idx  = cur_index(cnt_begin);
      run_d    = '0;
      if (run_q[0]) begin
        cmd.t0_v    = 1'b1;
        cmd.t0_char = CH_QUOTE;
      end else if (quoting_eff) begin
        pending_d = 1'b1;
      end else begin
        quoting_d = 1'b1;
      end
    end else if ((ch_i == CH_SPACE || ch_i == CH_TAB) && !quoting_eff) begin
      cmd.nbs     = run_q;
      cmd.idx     = cur_index(cnt_q);
      cmd.t0_v    = in_arg_q;
      cmd.t0_kind = K_ARGEND;
      in_arg_d    = 1'b0;
      run_d       = '0;
    end else begin
      in_arg_d    = 1'b1;
      cnt_d       = cnt_begin;
      cmd.nbs     = run_q;
      cmd.idx     = cur_index(cnt_begin);
      cmd.t0_v    = 1'b1;
      cmd.t0_char = ch_i;
      run_d       = '0;
    end
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = accept_i && (cmd.nbs != '0 || cmd.t0_v || cmd.t1_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_arg_q  <= 1'b0;
      quoting_q <= 1'b0;
      pending_q <= 1'b0;
      run_q     <= '0;
      cnt_q     <= '0;
    end else if (accept_i) begin
      in_arg_q  <= in_arg_d;
      quoting_q <= quoting_d;
      pending_q <= pending_d;
      run_q     <= run_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

// ===== src/cas_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_queue
// Short command queue decoupling the classifier from the result generator.
// ----------------------------------------------------------------------------
module cas_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cas_pkg::cmd_t       data_i,
  output logic                full_o,
  input  logic                pop_i,
  output cas_pkg::cmd_t       head_o,
  output logic                empty_o
);
  import cas_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/cas_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_back
// Expands queued commands into result items in an output register, one per
// cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module cas_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cas_pkg::cmd_t       head_i,
  input  logic                head_empty_i,
  output logic                head_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          out_char_o,
  output logic [7:0]          arg_number_o,
  output logic                last_o
);
  import cas_pkg::*;

  logic              out_v_q;
  kind_e             kind_q, kind_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic              last_q, last_d;
  logic [RUN_W-1:0]  bs_done_q;
  logic              t0_done_q;
  logic              take;
  logic              in_bs;
  logic              in_t0;

  assign take  = !head_empty_i && (!out_v_q || pop_i);
  assign in_bs = (bs_done_q < head_i.nbs);
  assign in_t0 = !in_bs && head_i.t0_v && !t0_done_q;

  always_comb begin
    if (in_bs) begin
      kind_d = K_CHAR;
      char_d = CH_BSLASH;
      num_d  = head_i.idx;
      last_d = (bs_done_q + 1'b1 == head_i.nbs) && !head_i.t0_v && !head_i.t1_v;
    end else if (in_t0) begin
      kind_d = head_i.t0_kind;
      char_d = head_i.t0_char;
      num_d  = head_i.idx;
      last_d = !head_i.t1_v;
    end else begin
      kind_d = K_STREND;
      char_d = '0;
      num_d  = head_i.t1_num;
      last_d = 1'b1;
    end
  end

  assign head_pop_o = take && last_d;

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= kind_d;
      char_q <= char_d;
      num_q  <= num_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      bs_done_q <= '0;
      t0_done_q <= 1'b0;
    end else begin
      if (take) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
      if (take) begin
        if (last_d) begin
          bs_done_q <= '0;
          t0_done_q <= 1'b0;
        end else if (in_bs) begin
          bs_done_q <= bs_done_q + 1'b1;
        end else begin
          t0_done_q <= 1'b1;
        end
      end
    end
  end

  assign empty_o      = !out_v_q;
  assign kind_o       = kind_q;
  assign out_char_o   = char_q;
  assign arg_number_o = num_q;
  assign last_o       = last_q;

endmodule

// ===== src/command_line_argument_splitter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_argument_splitter_top
// Splits a command-line string, one byte per item, into characters,
// argument ends and a string end.
// ----------------------------------------------------------------------------
// The splitter takes one byte per cycle whenever full is low; each byte is
// classified in the cycle it is accepted and the results it causes are
// queued as one command in a four-entry queue. The result side drains one
// result per cycle from the output register while pop is high, and a byte
// can cause up to 33 results (a released backslash run followed by further
// results); the queue absorbs such bursts and full rises only once four
// commands wait. A byte that causes no result is never queued. When the queue
// and the output register are empty, the first result of a byte is written
// into the queue and then into the output register before it appears on the
// result ports.
module command_line_argument_splitter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [7:0] out_char_o,
  output logic [7:0] arg_number_o,
  output logic       last_o
);
  import cas_pkg::*;

  logic accept;
  logic cmd_push;
  cmd_t cmd;
  cmd_t head;
  logic head_empty;
  logic head_pop;

  assign accept = push && !full;

  cas_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .ch_i       (ch_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd)
  );

  cas_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd),
    .full_o  (full),
    .pop_i   (head_pop),
    .head_o  (head),
    .empty_o (head_empty)
  );

  cas_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (head_empty),
    .head_pop_o   (head_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .kind_o       (kind_o),
    .out_char_o   (out_char_o),
    .arg_number_o (arg_number_o),
    .last_o       (last_o)
  );

endmodule

// ===== src/cas_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_checker
// Port-level checks on the argument splitter's result stream.
// ----------------------------------------------------------------------------
module cas_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [1:0] kind_o,
  input logic [7:0] out_char_o,
  input logic [7:0] arg_number_o,
  input logic       last_o
);
  import cas_pkg::*;

  // No result may be shown straight after reset is released.
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result shown straight after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (!empty && !pop) |=> (!empty && $stable(kind_o) && $stable(out_char_o) &&
                            $stable(arg_number_o) && $stable(last_o)))
    else $error("stalled result changed");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !empty |-> (kind_o == K_CHAR || kind_o == K_ARGEND || kind_o == K_STREND))
    else $error("undefined result kind");

  // The end of a string is always the final result of its item.
  a_strend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (!empty && kind_o == K_STREND) |-> last_o)
    else $error("string end not marked last");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (!empty && kind_o != K_CHAR) |-> (out_char_o == 8'd0))
    else $error("character set on an end result");

endmodule

bind command_line_argument_splitter_top cas_checker u_cas_checker (.*);

// ===== test/command_line_argument_splitter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_argument_splitter_top_tb
// Self-checking bench for the command-line argument splitter.
// ----------------------------------------------------------------------------
// Command lines are fed in byte by byte through the push/full queue port. A
// behavioural splitter in the bench works out the characters, argument ends
// and string ends that each accepted byte must produce; every result popped
// from the block is checked field by field against the oldest of them.
// Directed lines cover the quoting and backslash rules, random lines follow,
// with long backslash runs and a long result-side hold-off.
// ----------------------------------------------------------------------------
module command_line_argument_splitter_top_tb;

  import cas_pkg::*;

  // WATCHDOG_LIMIT bounds a stretch with no accepted byte and no popped result;
  // the longest correct one is the hold-off below, and a byte releasing 33
  // results under random pops gives far shorter idle stretches.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned MAX_REPORTS    = 20;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    kind_e      kind;
    logic [7:0] chr;
    logic [7:0] num;
    logic       last;
  } split_result_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       push         = 1'b0;
  logic [7:0] ch_i         = '0;
  logic       pop          = 1'b0;
  logic       full;
  logic       empty;
  logic [1:0] kind_o;
  logic [7:0] out_char_o;
  logic [7:0] arg_number_o;
  logic       last_o;

  command_line_argument_splitter_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .ch_i        (ch_i),
    .empty       (empty),
    .pop         (pop),
    .kind_o      (kind_o),
    .out_char_o  (out_char_o),
    .arg_number_o(arg_number_o),
    .last_o      (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Splitter state as the bench sees it.
  logic       in_arg;
  logic       quoting;
  logic       quote_held;
  logic [4:0] held_slashes;
  logic [7:0] arg_count;

  split_result_t byte_results[$];
  split_result_t pending_results[$];
  split_result_t want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned lines_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned stall_cycles  = 0;
  int unsigned idle_cycles   = 0;
  int unsigned hold_left     = 0;
  logic        hold_req      = 1'b0;
  logic        hold_ack      = 1'b0;

  // --------------------------------------------------------------------------
  // Behavioural splitter
  // --------------------------------------------------------------------------
  function automatic logic [7:0] arg_index();
    return (arg_count == 8'd0) ? 8'd0 : arg_count - 8'd1;
  endfunction

  function automatic void add_result(kind_e kind, logic [7:0] chr, logic [7:0] num);
    split_result_t r;
    r.kind = kind;
    r.chr  = chr;
    r.num  = num;
    r.last = 1'b0;
    byte_results.push_back(r);
  endfunction

  function automatic void open_argument();
    if (!in_arg) begin
      in_arg = 1'b1;
      if (arg_count < ARG_MAX) arg_count = arg_count + 8'd1;
    end
  endfunction

  function automatic void release_slashes(int unsigned count);
    for (int unsigned i = 0; i < count; i++) add_result(K_CHAR, CH_BSLASH, arg_index());
    held_slashes = '0;
  endfunction

  function automatic void clear_splitter();
    in_arg       = 1'b0;
    quoting      = 1'b0;
    quote_held   = 1'b0;
    held_slashes = '0;
    arg_count    = '0;
  endfunction

  // Works out the results of one accepted byte and queues them.
  function automatic void split_byte(logic [7:0] c);
    logic [4:0] run;
    bit         consumed;
    consumed = 1'b0;
    byte_results.delete();
    if (quote_held) begin
      // A quote seen while quoting: a second quote makes it literal,
      // anything else just closes the quoted section.
      quote_held = 1'b0;
      quoting    = 1'b0;
      if (c == CH_QUOTE) begin
        add_result(K_CHAR, CH_QUOTE, arg_index());
        consumed = 1'b1;
      end
    end
    if (!consumed) begin
      if (c == CH_NUL) begin
        release_slashes(held_slashes);
        if (in_arg) add_result(K_ARGEND, 8'd0, arg_index());
        add_result(K_STREND, 8'd0, arg_count);
        clear_splitter();
      end else if (c == CH_BSLASH) begin
        open_argument();
        if (held_slashes < SLASH_MAX) held_slashes = held_slashes + 5'd1;
      end else if (c == CH_QUOTE) begin
        run = held_slashes;
        open_argument();
        release_slashes(run >> 1);
        if (run[0]) add_result(K_CHAR, CH_QUOTE, arg_index());
        else if (quoting) quote_held = 1'b1;
        else quoting = 1'b1;
      end else if (c == CH_SPACE || c == CH_TAB) begin
        if (quoting) begin
          open_argument();
          release_slashes(held_slashes);
          add_result(K_CHAR, c, arg_index());
        end else begin
          release_slashes(held_slashes);
          if (in_arg) begin
            add_result(K_ARGEND, 8'd0, arg_index());
            in_arg = 1'b0;
          end
        end
      end else begin
        open_argument();
        release_slashes(held_slashes);
        add_result(K_CHAR, c, arg_index());
      end
    end
    if (byte_results.size() > 0) byte_results[byte_results.size()-1].last = 1'b1;
    foreach (byte_results[i]) pending_results.push_back(byte_results[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Returns at the edge that accepts the byte, with push still high so that
  // back-to-back bytes need no gap. Each idle cycle is drawn on its own, so
  // the share of idle cycles follows send_idle_pct.
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    ch_i <= c;
    do @(posedge clk_i); while (full);
    split_byte(c);
    bytes_sent++;
    if (c == CH_NUL) lines_sent++;
  endtask

  task automatic send_line(input byte_q_t s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b inside {CH_BSLASH, CH_QUOTE, CH_SPACE, CH_TAB});
    return b;
  endfunction

  function automatic logic [7:0] separator();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  // Any byte, leaning towards the ones with special meaning.
  function automatic logic [7:0] noise_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return CH_BSLASH;
    if (r < 35) return CH_QUOTE;
    if (r < 45) return CH_SPACE;
    if (r < 50) return CH_TAB;
    if (r < 53) return CH_NUL;
    return 8'($urandom_range(1, 255));
  endfunction

  // A command line: arguments built from plain, quoted, backslash and random
  // noise pieces, separated by whitespace and ended by NUL.
  function automatic byte_q_t random_command_line();
    byte_q_t s;
    if ($urandom_range(3) == 0) s.push_back(separator());
    repeat ($urandom_range(1, 5)) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(3))
          0: repeat ($urandom_range(1, 4)) s.push_back(plain_byte());
          1: begin
            s.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 4))
              s.push_back(($urandom_range(3) == 0) ? separator() : plain_byte());
            if ($urandom_range(2) == 0) begin
              s.push_back(CH_QUOTE);
              s.push_back(CH_QUOTE);
            end
            s.push_back(CH_QUOTE);
          end
          2: begin
            repeat ($urandom_range(0, 6)) s.push_back(CH_BSLASH);
            s.push_back($urandom_range(1) ? CH_QUOTE : plain_byte());
          end
          default: repeat ($urandom_range(1, 3)) s.push_back(noise_byte());
        endcase
      end
      repeat ($urandom_range(1, 2)) s.push_back(separator());
    end
    s.push_back(CH_NUL);
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking and receiver
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d char %02h arg %0d",
                                  kind_o, out_char_o, arg_number_o));
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (kind_o !== want.kind)
          report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                    results_seen, kind_o, want.kind));
        if (out_char_o !== want.chr)
          report_mismatch($sformatf("result %0d char %02h, expected %02h",
                                    results_seen, out_char_o, want.chr));
        if (arg_number_o !== want.num)
          report_mismatch($sformatf("result %0d arg %0d, expected %0d",
                                    results_seen, arg_number_o, want.num));
        if (last_o !== want.last)
          report_mismatch($sformatf("result %0d last %0b, expected %0b",
                                    results_seen, last_o, want.last));
      end
    end
    // The hold-off is counted here so that it runs alongside the sender.
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && push && full) stall_cycles++;
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("command_line_argument_splitter_top verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Empty quoted argument closed by a tab, even and odd runs before quotes,
  // doubled quote inside quotes, literal backslash, whitespace between
  // arguments and a held backslash flushed by the terminator.
  task automatic test_quoting_rules();
    send_line('{CH_QUOTE, CH_QUOTE, CH_TAB,
                CH_BSLASH, CH_BSLASH, CH_QUOTE, 8'h61, CH_SPACE,
                CH_QUOTE, CH_QUOTE,
                CH_BSLASH, CH_QUOTE, CH_BSLASH, 8'h62,
                8'hFF, 8'h01, CH_SPACE, CH_SPACE, CH_BSLASH, CH_NUL});
  endtask

  // An empty line, and a line ending just after a quote inside quotes.
  task automatic test_line_ends();
    send_line('{CH_NUL});
    send_line('{CH_QUOTE, 8'h71, CH_QUOTE, CH_NUL});
  endtask

  // Runs around the saturation point, ended by a quote, a character or NUL,
  // sometimes inside quotes.
  task automatic test_long_backslash_runs();
    byte_q_t s;
    repeat (4) begin
      s.delete();
      if ($urandom_range(1)) s.push_back(CH_QUOTE);
      repeat ($urandom_range(28, 40)) s.push_back(CH_BSLASH);
      case ($urandom_range(2))
        0: s.push_back(CH_QUOTE);
        1: s.push_back(plain_byte());
        default: ;
      endcase
      s.push_back(CH_NUL);
      send_line(s);
    end
  endtask

  task automatic test_random_lines(input int unsigned n_bytes);
    byte_q_t     s;
    int unsigned target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(4) == 0) begin
        s.delete();
        repeat ($urandom_range(1, 20)) s.push_back(noise_byte());
        s.push_back(CH_NUL);
      end else begin
        s = random_command_line();
      end
      send_line(s);
    end
  endtask

  // The receiver stops for a long stretch while bytes keep coming, so the
  // block must fill up and hold its input off.
  task automatic test_backpressure();
    byte_q_t s;
    hold_req <= ~hold_req;
    repeat (30) s.push_back(plain_byte());
    repeat (31) s.push_back(CH_BSLASH);
    s.push_back(plain_byte());
    s.push_back(CH_NUL);
    send_line(s);
  endtask

  task automatic finish_run();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d bytes in %0d lines and checked %0d results;", bytes_sent,
             lines_sent, results_seen);
    $display("input was held off for %0d cycles, %0d mismatches.", stall_cycles,
             error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("command_line_argument_splitter_top verification clean");
    end else begin
      $display("command_line_argument_splitter_top verification failed");
    end
    $finish;
  endtask

  initial begin
    clear_splitter();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 6;
    recv_idle_pct = 46;
    test_quoting_rules();
    test_line_ends();
    test_long_backslash_runs();

    send_idle_pct = 46;
    recv_idle_pct = 6;
    test_random_lines(80);
    test_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_lines(60);

    finish_run();
  end

endmodule
